### design/sfw_pkg.sv
// Shared types, constants and a helper function of the counting semaphore block.
package sfw_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int MAX_THREADS = 64;

  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 32;
  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_WAIT    = 2'd1,
    CMD_POST    = 2'd2,
    CMD_DESTROY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_STATE   = 2'd2,
    ST_BUSY    = 2'd3
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } queue_op_t;

  typedef struct packed {
    status_t             status;
    logic                caller_blocked;
    logic                woken_valid;
    logic [SLOT_W-1:0]   woken_slot;
    logic [COUNT_W-1:0]  count_now;
  } result_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

### design/sfw_if.sv
// Valid/ready channel interfaces for commands and results.
interface sfw_cmd_if;
  import sfw_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [SLOT_W-1:0] thread_slot;

  modport source (output valid, output command, output thread_slot, input ready);
  modport sink (input valid, input command, input thread_slot, output ready);
endinterface

interface sfw_rsp_if;
  import sfw_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               caller_blocked;
  logic               woken_valid;
  logic [SLOT_W-1:0]  woken_slot;
  logic [COUNT_W-1:0] count_now;

  modport source (output valid, output status, output caller_blocked, output woken_valid,
                  output woken_slot, output count_now, input ready);
  modport sink (input valid, input status, input caller_blocked, input woken_valid,
                input woken_slot, input count_now, output ready);
endinterface

### design/counting_semaphore_fifo_waiters.sv
// Top level of the counting semaphore with a queue of waiting thread slots.
//
// Usage: commands (init, wait, post, destroy) arrive as transactions on the
// cmd channel, each with the caller's thread slot. Every command produces
// exactly one result transaction on the rsp channel carrying the status, the
// blocked flag, an optional woken slot and the count after the command.
// The count loaded by init comes from a register written through cfg_wr_en
// and cfg_wr_data; write it only while no command is in flight.
//
// Timing: a command is decoded in the cycle it is accepted and its result is
// registered, so the result is shown in the cycle after acceptance. One
// command is accepted per cycle while results are taken; the limit is the
// single state update (count plus at most one queue push, pop or clear) done
// at each accept. The queue head is kept in a registered read of the slot
// memory, so a post takes the oldest waiter straight from head_data.
//
// Reset (rst, synchronous, active high) leaves the semaphore dead with a
// zero count, an empty queue and a zero init register; no clearing pass is
// needed. When the receiver stalls, the result register holds its
// transaction and cmd.ready drops until the result is taken.
module counting_semaphore_fifo_waiters (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [sfw_pkg::COUNT_W-1:0] cfg_wr_data,
  sfw_cmd_if.sink                     cmd,
  sfw_rsp_if.source                   rsp
);
  import sfw_pkg::*;

  logic [COUNT_W-1:0] init_count;
  logic               live;
  logic               live_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [FILL_W-1:0]  fill;
  logic [SLOT_W-1:0]  head_data;
  queue_op_t          qop;
  queue_op_t          qop_gated;
  result_t            res;
  logic               accept;

  // A new command enters whenever the result register is free or being
  // emptied in this same cycle.
  assign cmd.ready = !rsp.valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_count <= '0;
    end else if (cfg_wr_en) begin
      init_count <= cfg_wr_data;
    end
  end

  sfw_ctrl u_ctrl (
    .command     (cmd.command),
    .thread_slot (cmd.thread_slot),
    .init_count  (init_count),
    .live        (live),
    .count       (count),
    .fill        (fill),
    .head_data   (head_data),
    .live_next   (live_next),
    .count_next  (count_next),
    .qop         (qop),
    .res         (res)
  );

  // Queue operations take effect only for an accepted transaction.
  assign qop_gated = accept ? qop : '0;

  sfw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .op        (qop_gated),
    .push_data (cmd.thread_slot),
    .head_data (head_data),
    .fill      (fill)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      live  <= 1'b0;
      count <= '0;
    end else if (accept) begin
      live  <= live_next;
      count <= count_next;
    end
  end

  // Result register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status         <= res.status;
      rsp.caller_blocked <= res.caller_blocked;
      rsp.woken_valid    <= res.woken_valid;
      rsp.woken_slot     <= res.woken_slot;
      rsp.count_now      <= res.count_now;
    end
  end

endmodule

### design/sfw_queue.sv
// Circular queue of waiting thread slots with a registered head read.
module sfw_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  sfw_pkg::queue_op_t         op,
  input  logic [sfw_pkg::SLOT_W-1:0] push_data,
  output logic [sfw_pkg::SLOT_W-1:0] head_data,
  output logic [sfw_pkg::FILL_W-1:0] fill
);
  import sfw_pkg::*;

  logic [SLOT_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  head_next;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W-1:0]  tail_next;
  logic [FILL_W-1:0] fill_next;
  logic [SLOT_W-1:0] rd_data;
  logic [SLOT_W-1:0] byp_data;
  logic              byp;

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    if (op.clear) begin
      head_next = '0;
      tail_next = '0;
      fill_next = '0;
    end else begin
      if (op.pop) begin
        head_next = ptr_next(head);
        fill_next = fill - FILL_W'(1);
      end
      if (op.push) begin
        tail_next = ptr_next(tail);
        fill_next = fill + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

  // The entry at the next head is read every cycle; a write landing on that
  // same entry in the same cycle is forwarded instead.
  always_ff @(posedge clk) begin
    if (op.push && !op.clear) begin
      mem[tail] <= push_data;
    end
    rd_data  <= mem[head_next];
    byp      <= op.push && !op.clear && (tail == head_next);
    byp_data <= push_data;
  end

  assign head_data = byp ? byp_data : rd_data;

endmodule

### design/sfw_ctrl.sv
// Command decode: decides the result and the next semaphore and queue state.
module sfw_ctrl (
  input  logic [1:0]                  command,
  input  logic [sfw_pkg::SLOT_W-1:0]  thread_slot,
  input  logic [sfw_pkg::COUNT_W-1:0] init_count,
  input  logic                        live,
  input  logic [sfw_pkg::COUNT_W-1:0] count,
  input  logic [sfw_pkg::FILL_W-1:0]  fill,
  input  logic [sfw_pkg::SLOT_W-1:0]  head_data,
  output logic                        live_next,
  output logic [sfw_pkg::COUNT_W-1:0] count_next,
  output sfw_pkg::queue_op_t          qop,
  output sfw_pkg::result_t            res
);
  import sfw_pkg::*;

  logic has_waiters;
  logic queue_full;
  logic slot_bad;
  logic count_max;

  assign has_waiters = (fill != '0);
  assign queue_full  = (fill == FILL_W'(QUEUE_DEPTH));
  assign slot_bad    = ({1'b0, thread_slot} >= (SLOT_W + 1)'(MAX_THREADS));
  assign count_max   = (count == {COUNT_W{1'b1}});

  always_comb begin
    live_next          = live;
    count_next         = count;
    qop                = '0;
    res.status         = ST_OK;
    res.caller_blocked = 1'b0;
    res.woken_valid    = 1'b0;
    res.woken_slot     = '0;
    unique case (cmd_t'(command))
      CMD_INIT: begin
        live_next  = 1'b1;
        count_next = init_count;
        qop.clear  = 1'b1;
      end
      CMD_WAIT: begin
        priority if (!live) begin
          res.status = ST_STATE;
        end else if (count != '0) begin
          count_next = count - COUNT_W'(1);
        end else if (slot_bad) begin
          res.status = ST_STATE;
        end else if (queue_full) begin
          res.status = ST_BUSY;
        end else begin
          qop.push           = 1'b1;
          res.caller_blocked = 1'b1;
        end
      end
      CMD_POST: begin
        priority if (!live) begin
          res.status = ST_STATE;
        end else if (has_waiters) begin
          qop.pop         = 1'b1;
          res.woken_valid = 1'b1;
          res.woken_slot  = head_data;
        end else if (count_max) begin
          res.status = ST_INVALID;
        end else begin
          count_next = count + COUNT_W'(1);
        end
      end
      CMD_DESTROY: begin
        priority if (!live) begin
          res.status = ST_STATE;
        end else if (has_waiters) begin
          res.status = ST_BUSY;
        end else begin
          live_next  = 1'b0;
          count_next = '0;
          qop.clear  = 1'b1;
        end
      end
      default: begin
        res.status = ST_STATE;
      end
    endcase
    res.count_now = count_next;
  end

endmodule
